FILE: design/angle_pid_with_integral_freeze_core_defines.svh
// Assertion macros for the angle PID core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ANGLE_PID_WITH_INTEGRAL_FREEZE_CORE_DEFINES_SVH
`define ANGLE_PID_WITH_INTEGRAL_FREEZE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define APIDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("apidf check failed");
`define APIDF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("apidf check failed");
`else
`define APIDF_ASSERT(label, prop)
`define APIDF_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: design/apidf_pkg.sv
// Shared types and constants for the angle PID core.
// No dependencies.
package apidf_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 15;
  localparam int unsigned ProdW  = 33;
  localparam int unsigned AccW   = 24;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [AngleW:0] PosFloor = 17'd521;

  localparam logic [LimW-1:0] FreezeErrorRst = 15'd146;
  localparam logic [LimW-1:0] ActiveErrorRst = 15'd546;
  localparam logic [LimW-1:0] FreezeRateRst  = 15'd214;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4,
    REG_FREEZE_ERROR   = 3'd5,
    REG_ACTIVE_ERROR   = 3'd6,
    REG_FREEZE_RATE    = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
    logic [LimW-1:0]  integral_limit;
    logic [LimW-1:0]  output_limit;
    logic [LimW-1:0]  freeze_error;
    logic [LimW-1:0]  active_error;
    logic [LimW-1:0]  freeze_rate;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    op_e                      op;
    logic signed [AngleW-1:0] err;
    logic signed [ProdW-1:0]  p_term;
    logic signed [ProdW-1:0]  d_term;
    logic signed [ProdW-1:0]  i_step;
    logic                     decay;
    logic                     accum;
  } stage_t;

endpackage

FILE: design/angle_pid_with_integral_freeze_core.sv
// Angle-loop PID core for one axis with wrapped error and integral freeze.
// Depends on apidf_pkg, apidf_regs, apidf_front, apidf_integ and the defines header.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries op_i, measured_angle_i,
//   target_angle_i and measured_rate_i. op 0 runs one control step, op 1
//   clears the integral and returns a zero result.
//   Result channel (out_valid_o/out_ready_i) returns drive_o and wrapped_error_o,
//   one result per request, in request order.
//   Gains and limits are set over the APB port while no request is in flight.
// Timing:
//   Two register stages: a request is captured in the input stage register and
//   its result in the result register. One request per cycle is sustained while
//   the receiver is ready; the integral update closes in the result stage.
//   When the receiver stalls, both stages hold and in_ready_o drops.
// Reset:
//   Clears the integral and both valid flags; registers return to defaults.
`include "angle_pid_with_integral_freeze_core_defines.svh"
module angle_pid_with_integral_freeze_core import apidf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic signed [AngleW-1:0] measured_angle_i,
  input  logic signed [AngleW-1:0] target_angle_i,
  input  logic signed [AngleW-1:0] measured_rate_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [AngleW-1:0] drive_o,
  output logic signed [AngleW-1:0] wrapped_error_o
);

  cfg_t   cfg;
  stage_t stage;
  logic   en;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  apidf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apidf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .in_valid_i       (in_valid_i),
    .op_i             (op_i),
    .measured_angle_i (measured_angle_i),
    .target_angle_i   (target_angle_i),
    .measured_rate_i  (measured_rate_i),
    .cfg_i            (cfg),
    .stage_o          (stage)
  );

  apidf_integ u_integ (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .stage_i         (stage),
    .cfg_i           (cfg),
    .out_valid_o     (out_valid_o),
    .drive_o         (drive_o),
    .wrapped_error_o (wrapped_error_o)
  );

  `APIDF_ASSERT(a_drive_in_limit, out_valid_o |->
    (($signed(drive_o) <= $signed({1'b0, cfg.output_limit}))
     && ($signed(drive_o) >= -$signed({1'b0, cfg.output_limit}))))
  `APIDF_ASSERT_NEXT(a_stage_holds, stage.valid && !in_ready_o, stage.valid)
  `APIDF_ASSERT(a_result_from_stage, (out_valid_o && !$past(out_valid_o)) |-> $past(stage.valid))

endmodule

FILE: design/apidf_regs.sv
// APB configuration registers for the angle PID core.
// Depends on apidf_pkg.
module apidf_regs import apidf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.integral_limit <= '0;
      cfg_q.output_limit   <= '0;
      cfg_q.freeze_error   <= FreezeErrorRst;
      cfg_q.active_error   <= ActiveErrorRst;
      cfg_q.freeze_rate    <= FreezeRateRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:         cfg_q.gain_p         <= pwdata[GainW-1:0];
        REG_GAIN_I:         cfg_q.gain_i         <= pwdata[GainW-1:0];
        REG_GAIN_D:         cfg_q.gain_d         <= pwdata[GainW-1:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= pwdata[LimW-1:0];
        REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= pwdata[LimW-1:0];
        REG_FREEZE_ERROR:   cfg_q.freeze_error   <= pwdata[LimW-1:0];
        REG_ACTIVE_ERROR:   cfg_q.active_error   <= pwdata[LimW-1:0];
        REG_FREEZE_RATE:    cfg_q.freeze_rate    <= pwdata[LimW-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:         prdata = {16'b0, cfg_q.gain_p};
      REG_GAIN_I:         prdata = {16'b0, cfg_q.gain_i};
      REG_GAIN_D:         prdata = {16'b0, cfg_q.gain_d};
      REG_INTEGRAL_LIMIT: prdata = {17'b0, cfg_q.integral_limit};
      REG_OUTPUT_LIMIT:   prdata = {17'b0, cfg_q.output_limit};
      REG_FREEZE_ERROR:   prdata = {17'b0, cfg_q.freeze_error};
      REG_ACTIVE_ERROR:   prdata = {17'b0, cfg_q.active_error};
      REG_FREEZE_RATE:    prdata = {17'b0, cfg_q.freeze_rate};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: design/apidf_front.sv
// Input stage: wrapped error, P/D/I products and integral mode flags.
// Depends on apidf_pkg.
module apidf_front import apidf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic                     op_i,
  input  logic signed [AngleW-1:0] measured_angle_i,
  input  logic signed [AngleW-1:0] target_angle_i,
  input  logic signed [AngleW-1:0] measured_rate_i,
  input  cfg_t                     cfg_i,
  output stage_t                   stage_o
);

  logic signed [AngleW-1:0] err;
  logic signed [AngleW:0]   err_x;
  logic signed [AngleW:0]   rate_x;
  logic [AngleW:0]          aerr;
  logic [AngleW:0]          arate;
  logic signed [ProdW-1:0]  err_w;
  logic signed [ProdW-1:0]  rate_w;
  logic                     decay;
  logic                     accum;
  logic                     valid_q;
  stage_t                   stage_d;
  stage_t                   stage_q;

  assign err    = AngleW'(target_angle_i - measured_angle_i);
  assign err_x  = {err[AngleW-1], err};
  assign rate_x = {measured_rate_i[AngleW-1], measured_rate_i};
  assign aerr   = err[AngleW-1] ? (AngleW+1)'(-err_x) : err_x;
  assign arate  = measured_rate_i[AngleW-1] ? (AngleW+1)'(-rate_x) : rate_x;
  assign err_w  = {{(ProdW-AngleW){err[AngleW-1]}}, err};
  assign rate_w = {{(ProdW-AngleW){measured_rate_i[AngleW-1]}}, measured_rate_i};

  assign decay = (aerr < {2'b0, cfg_i.freeze_error}) && (arate < {2'b0, cfg_i.freeze_rate});
  assign accum = !decay && !err[AngleW-1] && (aerr > PosFloor)
                 && (aerr < {2'b0, cfg_i.active_error});

  always_comb begin
    stage_d        = stage_q;
    stage_d.valid  = in_valid_i;
    stage_d.op     = op_e'(op_i);
    stage_d.err    = err;
    stage_d.p_term = $signed({{(ProdW-GainW){1'b0}}, cfg_i.gain_p}) * err_w;
    stage_d.d_term = $signed({{(ProdW-GainW){1'b0}}, cfg_i.gain_d}) * rate_w;
    stage_d.i_step = $signed({{(ProdW-GainW){1'b0}}, cfg_i.gain_i}) * err_w;
    stage_d.decay  = decay;
    stage_d.accum  = accum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

FILE: design/apidf_integ.sv
// Integral update (leak, accumulate, clamp), output sum and saturation,
// plus the result register. Depends on apidf_pkg.
module apidf_integ import apidf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  stage_t                   stage_i,
  input  cfg_t                     cfg_i,
  output logic                     out_valid_o,
  output logic signed [AngleW-1:0] drive_o,
  output logic signed [AngleW-1:0] wrapped_error_o
);

  localparam int unsigned WideW = ProdW + 1;
  localparam int unsigned DecW  = 32;
  localparam int unsigned SumW  = ProdW + 2;

  logic signed [AccW-1:0]   acc_q;
  logic signed [DecW-1:0]   acc_d32;
  logic signed [DecW-1:0]   dec_prod;
  logic signed [DecW-1:0]   dec_val;
  logic signed [WideW-1:0]  acc_w;
  logic signed [WideW-1:0]  grow;
  logic signed [WideW-1:0]  pick;
  logic signed [WideW-1:0]  ilim;
  logic signed [WideW-1:0]  clamped;
  logic signed [AccW-1:0]   acc_d;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   quo;
  logic signed [SumW-1:0]   olim;
  logic signed [AngleW-1:0] drv;
  logic                     out_valid_q;
  logic signed [AngleW-1:0] drive_q;
  logic signed [AngleW-1:0] werr_q;
  logic                     clr;

  assign clr = (stage_i.op == OP_CLEAR);

  // leak by 251/256, truncated toward zero
  assign acc_d32  = DecW'(acc_q);
  assign dec_prod = (acc_d32 <<< 8) - (acc_d32 <<< 2) - acc_d32;
  assign dec_val  = (dec_prod + (dec_prod[DecW-1] ? 32'sd255 : 32'sd0)) >>> 8;

  assign acc_w = WideW'(acc_q);
  assign grow  = acc_w + WideW'(stage_i.i_step);
  assign ilim  = $signed({{(WideW-LimW-8){1'b0}}, cfg_i.integral_limit, 8'b0});

  always_comb begin
    priority if (stage_i.decay) begin
      pick = WideW'(dec_val);
    end else if (stage_i.accum) begin
      pick = grow;
    end else begin
      pick = acc_w;
    end
    priority if (pick > ilim) begin
      clamped = ilim;
    end else if (pick < -ilim) begin
      clamped = -ilim;
    end else begin
      clamped = pick;
    end
  end

  assign acc_d = clamped[AccW-1:0];

  assign sum  = SumW'(stage_i.p_term) + SumW'(acc_d) + SumW'(stage_i.d_term);
  assign quo  = (sum + (sum[SumW-1] ? SumW'(255) : SumW'(0))) >>> 8;
  assign olim = $signed({{(SumW-LimW){1'b0}}, cfg_i.output_limit});

  always_comb begin
    priority if (quo > olim) begin
      drv = olim[AngleW-1:0];
    end else if (quo < -olim) begin
      drv = AngleW'(-olim);
    end else begin
      drv = quo[AngleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (en_i) begin
      out_valid_q <= stage_i.valid;
      if (stage_i.valid) begin
        acc_q <= clr ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && stage_i.valid) begin
      drive_q <= clr ? '0 : drv;
      werr_q  <= clr ? '0 : stage_i.err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign wrapped_error_o = werr_q;

endmodule
